[src/mifc_pkg.sv]
`timescale 1ns / 1ps
// Shared definitions for the multichannel integral force controller:
// default sizes, reset values, action and register codes, and the
// command and status structures between controller and datapath.
package mifc_pkg;

  localparam int CHANNELS_DEF      = 7;
  localparam int ACC_WIDTH_DEF     = 56;
  localparam int PRODUCT_SHIFT_DEF = 24;

  // Shared multiplier: 33-bit signed by 17-bit signed.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [15:0]        GAIN_RST      = 16'd768;
  localparam logic signed [15:0] CMD_MIN_RST   = -16'sd32768;
  localparam logic signed [15:0] CMD_MAX_RST   = 16'sd32767;
  localparam logic signed [31:0] REFERENCE_RST = 32'sd1280;
  localparam logic signed [15:0] SCALE_RST     = 16'sd256;

  typedef enum logic [1:0] {
    ACT_CONTROL    = 2'd0,
    ACT_CALIBRATE  = 2'd1,
    ACT_CLEAR      = 2'd2,
    ACT_LOAD_SCALE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_GAIN    = 2'd0,
    REG_CMD_MIN = 2'd1,
    REG_CMD_MAX = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    MS_FORCE  = 2'd0,
    MS_DELTA  = 2'd1,
    MS_ACC_HI = 2'd2,
    MS_ACC_LO = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     aux_en;
    logic     force_en;
    logic     err_en;
    logic     acc_en;
    logic     hi_save;
    logic     cmd_en;
    logic     out_load;
  } mifc_cmd_t;

  typedef struct packed {
    action_t action;
    logic    ch_ok;
    logic    out_busy;
  } mifc_status_t;

endpackage

[src/mifc_ctrl.sv]
`timescale 1ns / 1ps
// Sequencing state machine of the integral force controller.
// Depends on mifc_pkg for the command and status structures.
module mifc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mifc_pkg::mifc_status_t status,
  output mifc_pkg::mifc_cmd_t    cmd
);
  import mifc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_MUL_F  = 10'b00_0000_0010,
    S_FORCE  = 10'b00_0000_0100,
    S_ERR    = 10'b00_0000_1000,
    S_MUL_D  = 10'b00_0001_0000,
    S_ACC    = 10'b00_0010_0000,
    S_MUL_HI = 10'b00_0100_0000,
    S_MUL_LO = 10'b00_1000_0000,
    S_CMD    = 10'b01_0000_0000,
    S_CLAMP  = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = MS_FORCE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MUL_F;
        end
      end
      S_MUL_F: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_FORCE;
        state_next  = S_FORCE;
      end
      S_FORCE: begin
        // Only an in-range control sample carries on to the integrator.
        if (status.action == ACT_CONTROL && status.ch_ok) begin
          cmd.force_en = 1'b1;
          state_next   = S_ERR;
        end else begin
          cmd.aux_en = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ERR: begin
        cmd.err_en = 1'b1;
        state_next = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_DELTA;
        state_next  = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_ACC_HI;
        state_next  = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_ACC_LO;
        cmd.hi_save = 1'b1;
        state_next  = S_CMD;
      end
      S_CMD: begin
        cmd.cmd_en = 1'b1;
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        // Hold here while the previous result has not yet been taken.
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/mifc_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the integral force controller: per-channel state, the shared
// multiplier, saturation and clamping, configuration and output registers.
// Depends on mifc_pkg; driven by mifc_ctrl through mifc_cmd_t.
module mifc_datapath #(
  parameter int CHANNELS      = mifc_pkg::CHANNELS_DEF,
  parameter int ACC_WIDTH     = mifc_pkg::ACC_WIDTH_DEF,
  parameter int PRODUCT_SHIFT = mifc_pkg::PRODUCT_SHIFT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mifc_pkg::mifc_cmd_t     cmd,
  output mifc_pkg::mifc_status_t  status,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic [1:0]             action,
  input  logic [2:0]             channel,
  input  logic signed [15:0]     raw_sample,
  input  logic [15:0]            elapsed_ticks,
  input  logic                   reference_valid,
  input  logic signed [31:0]     reference_value,
  input  logic signed [15:0]     scale_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             out_channel,
  output logic signed [31:0]     measured_force,
  output logic signed [31:0]     force_error,
  output logic signed [15:0]     motor_command,
  output logic                   command_clamped,
  output logic                   integrator_saturated
);
  import mifc_pkg::*;

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W    = ACC_WIDTH + 10;
  localparam int FULL_W   = ACC_WIDTH + MUL_B_W;
  localparam logic signed [SUM_W-1:0] ACC_MAX =
    {{(SUM_W - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN =
    {{(SUM_W - ACC_WIDTH + 1){1'b1}}, {(ACC_WIDTH - 1){1'b0}}};
  localparam logic signed [33:0] S32_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] S32_MIN = -34'sh0_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [15:0]        gain;
  logic signed [15:0] cmd_min;
  logic signed [15:0] cmd_max;

  // Per-channel state.
  logic signed [ACC_WIDTH-1:0] integ    [CHANNELS];
  logic signed [31:0]          f_ref    [CHANNELS];
  logic signed [31:0]          f_offset [CHANNELS];
  logic signed [15:0]          ch_scale [CHANNELS];

  // Captured transaction.
  action_t            act_r;
  logic [2:0]         ch_r;
  logic signed [15:0] raw_r;
  logic [15:0]        ticks_r;
  logic               ref_valid_r;
  logic signed [31:0] ref_value_r;
  logic signed [15:0] scale_value_r;

  // Working registers.
  logic signed [MUL_P_W-1:0]   prod;
  logic signed [MUL_P_W-1:0]   prod_hi;
  logic signed [31:0]          force_r;
  logic signed [31:0]          err_r;
  logic signed [ACC_WIDTH-1:0] acc_r;
  logic                        isat_r;
  logic signed [FULL_W-1:0]    shifted_r;

  logic [CH_IDX_W-1:0]         ch_idx;
  logic                        ch_ok;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [33:0]          force_diff;
  logic signed [33:0]          err_diff;
  logic signed [SUM_W-1:0]     acc_sum;
  logic signed [ACC_WIDTH-1:0] acc_new;
  logic                        acc_sat;
  logic signed [FULL_W-1:0]    full_prod;
  logic signed [FULL_W-1:0]    lim_max;
  logic signed [FULL_W-1:0]    lim_min;
  logic signed [15:0]          cmd_val;
  logic                        cmd_clamp;

  assign ch_idx = CH_IDX_W'(ch_r);
  assign ch_ok  = (32'(ch_r) < CHANNELS);

  assign status.action   = act_r;
  assign status.ch_ok    = ch_ok;
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain    <= GAIN_RST;
      cmd_min <= CMD_MIN_RST;
      cmd_max <= CMD_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN:    gain    <= cfg_data;
        REG_CMD_MIN: cmd_min <= cfg_data;
        REG_CMD_MAX: cmd_max <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r         <= action_t'(action);
      ch_r          <= channel;
      raw_r         <= raw_sample;
      ticks_r       <= elapsed_ticks;
      ref_valid_r   <= reference_valid;
      ref_value_r   <= reference_value;
      scale_value_r <= scale_value;
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (cmd.mul_sel)
      MS_FORCE: begin
        mul_a = MUL_A_W'(raw_r);
        mul_b = MUL_B_W'(ch_scale[ch_idx]);
      end
      MS_DELTA: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = {1'b0, ticks_r};
      end
      MS_ACC_HI: begin
        mul_a = MUL_A_W'($signed(acc_r[ACC_WIDTH-1:32]));
        mul_b = {1'b0, gain};
      end
      MS_ACC_LO: begin
        mul_a = {1'b0, acc_r[31:0]};
        mul_b = {1'b0, gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign force_diff = 34'(prod) - 34'(f_offset[ch_idx]);
  assign err_diff   = 34'(f_ref[ch_idx]) - 34'(force_r);

  // Saturating integrator update, evaluated wide enough to hold any sum.
  always_comb begin
    acc_sum = SUM_W'(integ[ch_idx]) + SUM_W'(prod);
    acc_sat = 1'b0;
    if (acc_sum > ACC_MAX) begin
      acc_new = ACC_MAX[ACC_WIDTH-1:0];
      acc_sat = 1'b1;
    end else if (acc_sum < ACC_MIN) begin
      acc_new = ACC_MIN[ACC_WIDTH-1:0];
      acc_sat = 1'b1;
    end else begin
      acc_new = acc_sum[ACC_WIDTH-1:0];
    end
  end

  assign full_prod = (FULL_W'(prod_hi) <<< 32) + FULL_W'(prod);

  // The upper limit is applied first, so inverted limits yield command_min.
  always_comb begin
    lim_max   = FULL_W'(cmd_max);
    lim_min   = FULL_W'(cmd_min);
    cmd_clamp = 1'b0;
    if (shifted_r > lim_max) begin
      cmd_val   = cmd_max;
      cmd_clamp = 1'b1;
    end else begin
      cmd_val = shifted_r[15:0];
    end
    if (shifted_r > lim_max ? (cmd_max < cmd_min) : (shifted_r < lim_min)) begin
      cmd_val   = cmd_min;
      cmd_clamp = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.hi_save) begin
      prod_hi <= prod;
    end
    if (cmd.force_en) begin
      force_r <= sat32(force_diff);
    end
    if (cmd.err_en) begin
      err_r <= sat32(err_diff);
    end
    if (cmd.acc_en) begin
      acc_r  <= acc_new;
      isat_r <= acc_sat;
    end
    if (cmd.cmd_en) begin
      shifted_r <= full_prod >>> PRODUCT_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        integ[i]    <= '0;
        f_ref[i]    <= REFERENCE_RST;
        f_offset[i] <= '0;
        ch_scale[i] <= SCALE_RST;
      end
    end else begin
      if (cmd.aux_en) begin
        if (act_r == ACT_CLEAR) begin
          for (int i = 0; i < CHANNELS; i++) begin
            integ[i] <= '0;
          end
        end else if (act_r == ACT_CALIBRATE && ch_ok) begin
          f_offset[ch_idx] <= prod[31:0];
        end else if (act_r == ACT_LOAD_SCALE && ch_ok) begin
          ch_scale[ch_idx] <= scale_value_r;
        end
      end
      if (cmd.force_en && ref_valid_r) begin
        f_ref[ch_idx] <= ref_value_r;
      end
      if (cmd.acc_en) begin
        integ[ch_idx] <= acc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_channel          <= ch_r;
      measured_force       <= force_r;
      force_error          <= err_r;
      motor_command        <= cmd_val;
      command_clamped      <= cmd_clamp;
      integrator_saturated <= isat_r;
    end
  end

endmodule

[src/multichannel_integral_force_controller.sv]
`timescale 1ns / 1ps
// Top level of the multichannel integral force controller.
// Instantiates mifc_ctrl and mifc_datapath; depends on mifc_pkg.
//
//   Channel   Signals                                   Direction
//   input     in_valid / in_ready, action .. scale_value  into block
//   output    out_valid / out_ready, out_channel ..       out of block
//   config    cfg_we, cfg_index, cfg_data                 into block
//
// A control sample steps through MUL_F, FORCE, ERR, MUL_D, ACC, MUL_HI,
// MUL_LO, CMD and CLAMP before its result is offered; the next transaction is
// taken only once the sequencer is back in IDLE. Calibrate, clear, load scale
// and out-of-range channels end after FORCE and give no result. The steps are
// set by the single shared 33 x 17 multiplier, used four times per control
// sample, and by at most one saturating add or compare per state.
// Reset is synchronous and restores the configuration registers, the output
// valid flag and every channel's state. A result waiting at the output does not
// block the next transaction; only a second result finding the output register still full holds the sequencer.
module multichannel_integral_force_controller #(
  parameter int CHANNELS      = mifc_pkg::CHANNELS_DEF,
  parameter int ACC_WIDTH     = mifc_pkg::ACC_WIDTH_DEF,
  parameter int PRODUCT_SHIFT = mifc_pkg::PRODUCT_SHIFT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [2:0]         channel,
  input  logic signed [15:0] raw_sample,
  input  logic [15:0]        elapsed_ticks,
  input  logic               reference_valid,
  input  logic signed [31:0] reference_value,
  input  logic signed [15:0] scale_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_channel,
  output logic signed [31:0] measured_force,
  output logic signed [31:0] force_error,
  output logic signed [15:0] motor_command,
  output logic               command_clamped,
  output logic               integrator_saturated
);
  import mifc_pkg::*;

  mifc_cmd_t    cmd;
  mifc_status_t status;

  mifc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mifc_datapath #(
    .CHANNELS      (CHANNELS),
    .ACC_WIDTH     (ACC_WIDTH),
    .PRODUCT_SHIFT (PRODUCT_SHIFT)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .status               (status),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .action               (action),
    .channel              (channel),
    .raw_sample           (raw_sample),
    .elapsed_ticks        (elapsed_ticks),
    .reference_valid      (reference_valid),
    .reference_value      (reference_value),
    .scale_value          (scale_value),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_channel          (out_channel),
    .measured_force       (measured_force),
    .force_error          (force_error),
    .motor_command        (motor_command),
    .command_clamped      (command_clamped),
    .integrator_saturated (integrator_saturated)
  );

endmodule
